FILE: hw/rtl/uvlt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unique value list table package
// Shared sizes, command and status codes, and transaction types.
// ----------------------------------------------------------------------------
package uvlt_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Command codes on the cmd port
  localparam logic [CMD_W-1:0] CMD_ADD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEL  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST = 2'd2;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_DEL,
    OP_LIST
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOTFOUND  = 3'd3,
    ST_ENTRY     = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_SEARCH,
    E_SHIFT,
    E_LIST
  } eng_state_t;

  typedef struct packed {
    op_t               op;
    logic [DATA_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [DATA_W-1:0] item;
    logic              last;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/uvlt_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Command front end
// Accepts transactions, decodes the command, drops the unused code and
// queues the rest for the engine in a two-entry queue.
// ----------------------------------------------------------------------------
module uvlt_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic [uvlt_pkg::CMD_W-1:0]   cmd,
  input  wire logic signed [uvlt_pkg::DATA_W-1:0] value,
  output logic                              cq_valid,
  output uvlt_pkg::cmd_t                    cq_data,
  input  wire logic                         cq_pop
);
  import uvlt_pkg::*;

  cmd_t       q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       accept;
  logic       keep;
  cmd_t       dec;

  assign full     = (cnt == 2'd2);
  assign accept   = push && !full;
  assign cq_valid = (cnt != 2'd0);
  assign cq_data  = q[rd_ptr];

  always_comb begin
    dec.value = value;
    dec.op    = OP_ADD;
    keep      = 1'b1;
    case (cmd)
      CMD_ADD:  dec.op = OP_ADD;
      CMD_DEL:  dec.op = OP_DEL;
      CMD_LIST: dec.op = OP_LIST;
      default:  keep   = 1'b0;  // drop the unused code
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (accept && keep) begin
        wr_ptr <= ~wr_ptr;
      end
      if (cq_pop && cq_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      cnt <= cnt + 2'(accept && keep) - 2'(cq_pop && cq_valid);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/uvlt_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// List engine
// Holds the entry memory, walks it one entry a cycle for search, compaction
// and listing (listing only while the output queue has room), and queues results in a two-entry output queue.
// ----------------------------------------------------------------------------
module uvlt_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cq_valid,
  input  wire uvlt_pkg::cmd_t                cq_data,
  output logic                               cq_pop,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [uvlt_pkg::STATUS_W-1:0]      status,
  output logic signed [uvlt_pkg::DATA_W-1:0] item,
  output logic                               last
);
  import uvlt_pkg::*;

  // Entry memory: one write port, one registered read port
  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;
  logic [IDX_W-1:0]  rd_addr;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;

  eng_state_t        state, state_next;
  logic [CNT_W-1:0]  idx, idx_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [CNT_W-1:0]  idx_inc;
  op_t               op;
  logic [DATA_W-1:0] val;
  logic              load;

  // Result queue
  result_t    rq [2];
  logic       rq_wr, rq_rd;
  logic [1:0] rq_cnt;
  logic       rq_full;
  logic       res_push;
  result_t    res;
  logic       res_pop;

  assign idx_inc = idx + CNT_W'(1);
  assign rd_addr = idx_next[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op  <= cq_data.op;
      val <= cq_data.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      idx   <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      count <= count_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    count_next = count;
    load       = 1'b0;
    cq_pop     = 1'b0;
    we         = 1'b0;
    waddr      = idx[IDX_W-1:0];
    wdata      = val;
    res_push   = 1'b0;
    res.status = ST_ADDED;
    res.item   = val;
    res.last   = 1'b1;
    case (state)
      E_IDLE: begin
        idx_next = '0;
        if (cq_valid) begin
          if (cq_data.op == OP_LIST && count == '0) begin
            // empty list: one result, item zero
            res.status = ST_EMPTY;
            res.item   = '0;
            if (!rq_full) begin
              res_push = 1'b1;
              cq_pop   = 1'b1;
            end
          end else begin
            cq_pop     = 1'b1;
            load       = 1'b1;
            state_next = (cq_data.op == OP_LIST) ? E_LIST : E_SEARCH;
          end
        end
      end
      E_SEARCH: begin
        // rd_data holds entry idx while idx < count
        if (idx == count) begin
          if (op == OP_DEL) begin
            res.status = ST_NOTFOUND;
          end else if (count == CNT_W'(CAPACITY)) begin
            res.status = ST_FULL;
          end else begin
            res.status = ST_ADDED;
          end
          if (!rq_full) begin
            res_push   = 1'b1;
            state_next = E_IDLE;
            if (op == OP_ADD && count != CNT_W'(CAPACITY)) begin
              we         = 1'b1;
              waddr      = count[IDX_W-1:0];
              count_next = count + CNT_W'(1);
            end
          end
        end else if (rd_data == val) begin
          if (op == OP_ADD) begin
            res.status = ST_DUPLICATE;
            if (!rq_full) begin
              res_push   = 1'b1;
              state_next = E_IDLE;
            end
          end else begin
            idx_next   = idx_inc;
            state_next = E_SHIFT;
          end
        end else begin
          idx_next = idx_inc;
        end
      end
      E_SHIFT: begin
        // move entry idx down one place until the tail is reached
        if (idx == count) begin
          res.status = ST_DELETED;
          if (!rq_full) begin
            res_push   = 1'b1;
            count_next = count - CNT_W'(1);
            state_next = E_IDLE;
          end
        end else begin
          we       = 1'b1;
          waddr    = IDX_W'(idx - CNT_W'(1));
          wdata    = rd_data;
          idx_next = idx_inc;
        end
      end
      E_LIST: begin
        res.status = ST_ENTRY;
        res.item   = rd_data;
        res.last   = (idx_inc == count);
        if (!rq_full) begin
          res_push = 1'b1;
          if (idx_inc == count) begin
            state_next = E_IDLE;
          end else begin
            idx_next = idx_inc;
          end
        end
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  // Output queue
  assign rq_full = (rq_cnt == 2'd2);
  assign empty   = (rq_cnt == 2'd0);
  assign res_pop = pop && !empty;
  assign status  = rq[rq_rd].status;
  assign item    = rq[rq_rd].item;
  assign last    = rq[rq_rd].last;

  always_ff @(posedge clk) begin
    if (res_push) begin
      rq[rq_wr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr  <= 1'b0;
      rq_rd  <= 1'b0;
      rq_cnt <= 2'd0;
    end else begin
      if (res_push) begin
        rq_wr <= ~rq_wr;
      end
      if (res_pop) begin
        rq_rd <= ~rq_rd;
      end
      rq_cnt <= rq_cnt + 2'(res_push) - 2'(res_pop);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/unique_value_list_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Unique value list table
// Ordered list of distinct 32-bit values with add, delete and list commands.
// ----------------------------------------------------------------------------
// Both sides are queues: push a command while full is low, pop results while
// empty is low. A two-entry command queue lets new transactions in while the
// engine works. Add and delete take the command, search the stored entries in
// order and then issue the result. An add that hits a duplicate stops at the
// match; a delete walks to the match and then closes the gap one entry per
// cycle behind it. A list command gives one result per cycle while the result
// queue has room. The single read port of the entry memory makes the engine
// walk the entries one at a time. A stalled result side holds the engine.
// ----------------------------------------------------------------------------
module unique_value_list_table_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [uvlt_pkg::CMD_W-1:0]    cmd,
  input  wire logic signed [uvlt_pkg::DATA_W-1:0] value,
  output logic                               empty,
  input  wire logic                          pop,
  output logic [uvlt_pkg::STATUS_W-1:0]      status,
  output logic signed [uvlt_pkg::DATA_W-1:0] item,
  output logic                               last
);
  import uvlt_pkg::*;

  logic cq_valid;
  cmd_t cq_data;
  logic cq_pop;

  uvlt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .cmd      (cmd),
    .value    (value),
    .cq_valid (cq_valid),
    .cq_data  (cq_data),
    .cq_pop   (cq_pop)
  );

  uvlt_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .cq_valid (cq_valid),
    .cq_data  (cq_data),
    .cq_pop   (cq_pop),
    .empty    (empty),
    .pop      (pop),
    .status   (status),
    .item     (item),
    .last     (last)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/uvlt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Port checker
// Watches the top level ports for result queue behavior over time.
// ----------------------------------------------------------------------------
module uvlt_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          full,
  input wire logic                          empty,
  input wire logic                          pop,
  input wire logic [uvlt_pkg::STATUS_W-1:0] status,
  input wire logic signed [uvlt_pkg::DATA_W-1:0] item,
  input wire logic                          last
);
  import uvlt_pkg::*;

  // Reset leaves no result waiting and room for commands
  a_reset_clears: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not cleared by reset");

  // A waiting result holds until popped
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(status) && $stable(item) && $stable(last)))
    else $error("waiting result changed");

  // Only list entries may leave the transaction open
  a_last_rule: assert property (@(posedge clk) disable iff (rst)
    (!empty && !last) |-> (status == ST_ENTRY))
    else $error("non-entry result without last");

  // An empty listing reports item zero
  a_empty_item: assert property (@(posedge clk) disable iff (rst)
    (!empty && status == ST_EMPTY) |-> (item == '0 && last))
    else $error("empty listing result malformed");

  // A status code beyond the defined set never appears
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (status != 3'd7))
    else $error("undefined status code");

endmodule

bind unique_value_list_table_unit uvlt_checker u_uvlt_checker (
  .clk    (clk),
  .rst    (rst),
  .full   (full),
  .empty  (empty),
  .pop    (pop),
  .status (status),
  .item   (item),
  .last   (last)
);
`default_nettype wire
